// ===== rtl/sacl_pkg.sv =====
// package for the slab autocorrelation length unit
// shared types, constants and register indexes; no dependencies
`timescale 1ns / 1ps
package sacl_pkg;

    localparam int MaxRowLength = 64;
    localparam int MaxRowCount  = 64;
    localparam int SampleWidth  = 16;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_LENGTH   = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [1:0] REG_CELL_SPACING = 2'd2;

    typedef struct packed {
        logic signed [15:0] momentum_x;
        logic [15:0]        density;
        logic               plane_end;
    } t_in_item;

    typedef struct packed {
        logic [15:0] plane_number;
        logic [5:0]  momentum_lag;
        logic [5:0]  velocity_lag;
        logic [5:0]  density_lag;
        logic [21:0] momentum_length;
        logic [21:0] velocity_length;
        logic [21:0] density_length;
        logic [2:0]  zero_energy;
    } t_out_item;

    // divider handshake
    typedef struct packed {
        logic        start;
        logic [15:0] mag;
        logic [15:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [23:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/sacl_div.sv =====
// iterative unsigned divider, one quotient bit per cycle
// depends on sacl_pkg
`timescale 1ns / 1ps
module sacl_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sacl_pkg::t_div_req i_req,
    output sacl_pkg::t_div_rsp o_rsp
);
    logic [23:0] r_num, n_num;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [16:0] w_try;

    // shift-subtract step
    always_comb begin
        w_try = {r_rem[15:0], r_num[23]};
        n_num = {r_num[22:0], 1'b0};
        n_rem = w_try;
        if (w_try >= {1'b0, r_den}) begin
            n_rem = w_try - {1'b0, r_den};
            n_num[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd23;
                r_num  <= {i_req.mag, 8'd0};
                r_den  <= i_req.den;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= n_num;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;
endmodule

// ===== rtl/slab_autocorrelation_length_unit.sv =====
// slab autocorrelation length unit: top level, sample stores and correlation sequencer
// depends on sacl_pkg and sacl_div
//
// Use: write row_length, row_count, cell_spacing on the config port while idle.
// Cells enter on start when busy is low, x fastest, row by row. Each cell keeps
// busy high while the velocity divider runs (24 quotient bits, then the
// write-back), so a cell is taken only after the last one is written; a
// zero-density cell skips the divider and is written from S_CLR instead.
// A cell with plane_end set starts the correlation pass right after its
// write-back: for each lag l, one pair per cycle over rows*(len-l) pairs (two
// reads per store, one multiply-accumulate per quantity), then the drain state
// S_ACC and the lag-search state S_PICK. After the S_OUT state that follows
// the last lag, the result pulses on o_valid for one cycle; busy falls in the same cycle.
// Reset clears the state, cell and plane counts, configuration and o_valid; the
// stores need no clearing. The receiver cannot stall; the result is shown once.
`timescale 1ns / 1ps
module slab_autocorrelation_length_unit #(
    parameter int MAX_ROW_LENGTH = sacl_pkg::MaxRowLength,
    parameter int MAX_ROW_COUNT  = sacl_pkg::MaxRowCount
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  sacl_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output sacl_pkg::t_out_item o_item
);
    localparam int Depth = MAX_ROW_LENGTH * MAX_ROW_COUNT;
    localparam int AW    = $clog2(Depth);
    localparam int LW    = $clog2(MAX_ROW_LENGTH);
    localparam int CW    = $clog2(Depth + 1);
    localparam int RW    = $clog2(MAX_ROW_COUNT + 1);
    localparam int LNW   = $clog2(MAX_ROW_LENGTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_CLR  = 7'b0000100,
        S_RUN  = 7'b0001000,
        S_ACC  = 7'b0010000,
        S_PICK = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;

    // configuration
    logic [6:0]  r_row_length, r_row_count;
    logic [15:0] r_spacing;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= 7'd64;
            r_row_count  <= 7'd64;
            r_spacing    <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sacl_pkg::REG_ROW_LENGTH:   r_row_length <= i_cfg_data[6:0];
                sacl_pkg::REG_ROW_COUNT:    r_row_count  <= i_cfg_data[6:0];
                sacl_pkg::REG_CELL_SPACING: r_spacing    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [LNW-1:0] w_len;
    logic [RW-1:0]  w_rows;
    always_comb begin
        if (r_row_length == 7'd0) w_len = LNW'(1);
        else if (32'(r_row_length) > MAX_ROW_LENGTH) w_len = LNW'(MAX_ROW_LENGTH);
        else w_len = LNW'(r_row_length);
        if (r_row_count == 7'd0) w_rows = RW'(1);
        else if (32'(r_row_count) > MAX_ROW_COUNT) w_rows = RW'(MAX_ROW_COUNT);
        else w_rows = RW'(r_row_count);
    end

    // cell intake and velocity divide
    logic signed [15:0] r_m;
    logic [15:0]        r_d;
    logic               r_end;
    logic [CW-1:0]      r_cells;
    logic [15:0]        r_plane;
    sacl_pkg::t_div_req w_dreq;
    sacl_pkg::t_div_rsp w_drsp;
    logic [15:0]        w_vel;

    assign w_dreq.start = (r_state == S_IDLE) && start && (i_item.density != 16'd0);
    assign w_dreq.mag   = i_item.momentum_x[15] ? 16'(-i_item.momentum_x)
                                                : i_item.momentum_x;
    assign w_dreq.den   = i_item.density;

    sacl_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    // saturate signed velocity
    always_comb begin
        if (r_d == 16'd0) w_vel = 16'd0;
        else if (r_m[15]) w_vel = (w_drsp.quot > 24'd32768) ? 16'h8000
                                  : 16'(-w_drsp.quot[15:0]);
        else w_vel = (w_drsp.quot > 24'd32767) ? 16'h7fff : w_drsp.quot[15:0];
    end

    // sample stores, two read ports each
    logic [15:0] mem_m [Depth];
    logic [15:0] mem_v [Depth];
    logic [15:0] mem_d [Depth];
    logic [AW-1:0] w_ra, w_rb;
    logic [15:0] r_ma, r_mb, r_va, r_vb, r_da, r_db;
    logic        w_we;
    assign w_we = ((r_state == S_DIV && w_drsp.done) || (r_state == S_CLR)) &&
                  (r_cells < CW'(Depth)) && (r_state == S_DIV || r_d == 16'd0);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_m[r_cells[AW-1:0]] <= r_m;
            mem_v[r_cells[AW-1:0]] <= w_vel;
            mem_d[r_cells[AW-1:0]] <= r_d;
        end
        r_ma <= mem_m[w_ra]; r_mb <= mem_m[w_rb];
        r_va <= mem_v[w_ra]; r_vb <= mem_v[w_rb];
        r_da <= mem_d[w_ra]; r_db <= mem_d[w_rb];
    end

    // correlation sequencer
    logic [LW-1:0]  r_lag, r_x;
    logic [RW-1:0]  r_r;
    logic [AW+1:0]  r_base;
    logic           r_rd_ok;
    logic signed [47:0] r_acc_m, r_acc_v, r_acc_d;
    logic signed [47:0] r_c0_m, r_c0_v, r_c0_d;
    logic [47:0] r_bd_m, r_bd_v, r_bd_d;
    logic [LW-1:0] r_bl_m, r_bl_v, r_bl_d;
    logic [LW-1:0] w_last;
    logic [AW+1:0] w_i, w_j;
    logic          w_pair_last;

    assign w_last = LW'(w_len - LNW'(1));
    assign w_i    = r_base + (AW+2)'(r_x);
    assign w_j    = w_i + (AW+2)'(r_lag);
    assign w_ra   = w_i[AW-1:0];
    assign w_rb   = w_j[AW-1:0];
    assign w_pair_last = ((LNW'(r_x) + LNW'(r_lag)) == w_len - LNW'(1)) &&
                         (r_r == w_rows - RW'(1));

    // distance |2c - c0|
    function automatic logic [47:0] half_gap(input logic signed [47:0] c,
                                             input logic signed [47:0] c0);
        logic signed [48:0] t;
        t = {c, 1'b0} - 49'(c0);
        return t[48] ? 48'(-t) : 48'(t);
    endfunction

    // late accumulate of the pair read last cycle
    logic signed [31:0] w_pm, w_pv;
    logic [31:0]        w_pd;
    assign w_pm = $signed(r_ma) * $signed(r_mb);
    assign w_pv = $signed(r_va) * $signed(r_vb);
    assign w_pd = r_da * r_db;

    logic [47:0] w_dm, w_dv, w_dd;
    assign w_dm = half_gap(r_acc_m, r_c0_m);
    assign w_dv = half_gap(r_acc_v, r_c0_v);
    assign w_dd = half_gap(r_acc_d, r_c0_d);

    logic r_acc_pend, r_lag_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cells <= '0;
            r_plane <= '0;
            o_valid <= 1'b0;
            r_acc_pend <= 1'b0;
            r_lag_done <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (start) begin
                    r_m   <= i_item.momentum_x;
                    r_d   <= i_item.density;
                    r_end <= i_item.plane_end;
                    // zero density writes directly via S_CLR path
                    r_state <= (i_item.density == 16'd0) ? S_CLR : S_DIV;
                end
                S_DIV, S_CLR: if (r_state == S_CLR || w_drsp.done) begin
                    if (r_cells < CW'(Depth)) r_cells <= r_cells + CW'(1);
                    if (r_end) begin
                        r_lag <= '0; r_x <= '0; r_r <= '0; r_base <= '0;
                        r_acc_m <= '0; r_acc_v <= '0; r_acc_d <= '0;
                        r_acc_pend <= 1'b0; r_lag_done <= 1'b0;
                        r_state <= S_RUN;
                    end else r_state <= S_IDLE;
                end
                S_RUN: begin
                    // issue a pair read, accumulate the previous one
                    r_rd_ok    <= (w_j < (AW+2)'(r_cells));
                    r_acc_pend <= 1'b1;
                    if (r_acc_pend && r_rd_ok) begin
                        r_acc_m <= r_acc_m + 48'(w_pm);
                        r_acc_v <= r_acc_v + 48'(w_pv);
                        r_acc_d <= r_acc_d + 48'({16'd0, w_pd});
                    end
                    if (w_pair_last) begin
                        r_state <= S_ACC;
                    end else if ((LNW'(r_x) + LNW'(r_lag)) == w_len - LNW'(1)) begin
                        r_x <= '0;
                        r_r <= r_r + RW'(1);
                        r_base <= r_base + (AW+2)'(w_len);
                    end else r_x <= r_x + LW'(1);
                end
                S_ACC: begin
                    // finish last pair of this lag
                    if (r_rd_ok) begin
                        r_acc_m <= r_acc_m + 48'(w_pm);
                        r_acc_v <= r_acc_v + 48'(w_pv);
                        r_acc_d <= r_acc_d + 48'({16'd0, w_pd});
                    end
                    r_acc_pend <= 1'b0;
                    r_state <= S_PICK;
                end
                S_PICK: begin
                    // lag search, running: lag 0 sets c0, later lags compare
                    if (r_lag == '0) begin
                        r_c0_m <= r_acc_m; r_c0_v <= r_acc_v; r_c0_d <= r_acc_d;
                        r_bd_m <= half_gap(r_acc_m, r_acc_m);
                        r_bd_v <= half_gap(r_acc_v, r_acc_v);
                        r_bd_d <= half_gap(r_acc_d, r_acc_d);
                        r_bl_m <= '0; r_bl_v <= '0; r_bl_d <= '0;
                    end else begin
                        if (w_dm <= r_bd_m) begin r_bd_m <= w_dm; r_bl_m <= r_lag; end
                        if (w_dv <= r_bd_v) begin r_bd_v <= w_dv; r_bl_v <= r_lag; end
                        if (w_dd <= r_bd_d) begin r_bd_d <= w_dd; r_bl_d <= r_lag; end
                    end
                    r_acc_m <= '0; r_acc_v <= '0; r_acc_d <= '0;
                    if (r_lag == w_last) r_state <= S_OUT;
                    else begin
                        r_lag <= r_lag + LW'(1);
                        r_x <= '0; r_r <= '0; r_base <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    r_plane <= r_plane + 16'd1;
                    r_cells <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // when len is 1, lag-0 handling above leaves best = 0 = len-1
    logic [LW-1:0] w_lm, w_lv, w_ld;
    logic [2:0]    w_z;
    assign w_z  = {r_c0_d == 0, r_c0_v == 0, r_c0_m == 0};
    assign w_lm = w_z[0] ? w_last : r_bl_m;
    assign w_lv = w_z[1] ? w_last : r_bl_v;
    assign w_ld = w_z[2] ? w_last : r_bl_d;

    // result register
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_item.plane_number    <= r_plane;
            o_item.momentum_lag    <= 6'(w_lm);
            o_item.velocity_lag    <= 6'(w_lv);
            o_item.density_lag     <= 6'(w_ld);
            o_item.momentum_length <= 22'(32'(w_lm) * 32'(r_spacing));
            o_item.velocity_length <= 22'(32'(w_lv) * 32'(r_spacing));
            o_item.density_length  <= 22'(32'(w_ld) * 32'(r_spacing));
            o_item.zero_energy     <= w_z;
        end
    end

    assign busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_valid_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_OUT) else $error("result without search end");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("item not taken");
    a_cells_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cells <= CW'(Depth)) else $error("cell count overflow");
`endif
endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the slab autocorrelation length unit: directed and random planes
// checks every result against a built-in lag predictor; depends on sacl_pkg and the rtl
`timescale 1ns / 1ps
module tb_top;

    localparam int StoreDepth = sacl_pkg::MaxRowLength * sacl_pkg::MaxRowCount;
    localparam int SettleCycles = 60;
    localparam int WatchdogLimit = 400000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    sacl_pkg::t_in_item  i_item = '0;
    logic                i_cfg_we = 1'b0;
    logic [1:0]          i_cfg_idx = sacl_pkg::REG_ROW_LENGTH;
    logic [15:0]         i_cfg_data = '0;
    logic                o_valid;
    sacl_pkg::t_out_item o_item;

    // predictor state
    logic signed [15:0] mom_mem [StoreDepth];
    logic signed [15:0] vel_mem [StoreDepth];
    logic [15:0]        den_mem [StoreDepth];
    int                 cells_held = 0;
    logic [15:0]        planes_done = '0;
    logic [6:0]         row_len_reg = 7'd64;
    logic [6:0]         row_cnt_reg = 7'd64;
    logic [15:0]        spacing_reg = 16'd256;

    sacl_pkg::t_out_item expected_lengths[$];
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        cells_sent = 0;
    bit        no_idle = 1'b0;

    always #6 i_clk = ~i_clk;

    slab_autocorrelation_length_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_item     (o_item)
    );

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d (plane %0d)", what, got, want,
                 o_item.plane_number);
        mismatches++;
    endtask

    // velocity = |m|*256/d with the sign of m, saturated to 16 bits
    function automatic logic [15:0] velocity_of(input logic signed [15:0] m,
                                                input logic [15:0] d);
        longint mag;
        longint q;
        if (d == 0) return '0;
        mag = (m < 0) ? -longint'(m) : longint'(m);
        q = (mag << 8) / longint'(d);
        if (m < 0) q = -q;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // lag nearest half of lag-0 energy; ties keep the larger lag
    function automatic int half_lag(input longint c[sacl_pkg::MaxRowLength], input int len,
                                    output bit zero);
        int best;
        longint bestd;
        longint d;
        best = len - 1;
        zero = (c[0] == 0);
        if (zero) return best;
        bestd = 2 * c[best] - c[0];
        if (bestd < 0) bestd = -bestd;
        for (int l = len - 1; l >= 0; l--) begin
            d = 2 * c[l] - c[0];
            if (d < 0) d = -d;
            if (d < bestd) begin
                bestd = d;
                best = l;
            end
        end
        return best;
    endfunction

    // store the cell and, on the plane end, work out the expected lengths
    task automatic correlate_plane(input sacl_pkg::t_in_item cur);
        longint    sums [3][sacl_pkg::MaxRowLength];
        longint    c [sacl_pkg::MaxRowLength];
        int        len;
        int        rows;
        int        lag [3];
        int        i;
        int        j;
        bit        z;
        sacl_pkg::t_out_item res;
        if (cells_held < StoreDepth) begin
            mom_mem[cells_held] = cur.momentum_x;
            vel_mem[cells_held] = velocity_of(cur.momentum_x, cur.density);
            den_mem[cells_held] = cur.density;
            cells_held++;
        end
        if (!cur.plane_end) return;
        len = (row_len_reg < 1) ? 1 : ((row_len_reg > sacl_pkg::MaxRowLength)
                                       ? sacl_pkg::MaxRowLength : row_len_reg);
        rows = (row_cnt_reg < 1) ? 1 : ((row_cnt_reg > sacl_pkg::MaxRowCount)
                                        ? sacl_pkg::MaxRowCount : row_cnt_reg);
        for (int q = 0; q < 3; q++)
            for (int l = 0; l < sacl_pkg::MaxRowLength; l++) sums[q][l] = 0;
        for (int l = 0; l < len; l++)
            for (int r = 0; r < rows; r++)
                for (int x = 0; x + l < len; x++) begin
                    i = r * len + x;
                    j = i + l;
                    if (j < cells_held) begin
                        sums[0][l] += longint'(mom_mem[i]) * longint'(mom_mem[j]);
                        sums[1][l] += longint'(vel_mem[i]) * longint'(vel_mem[j]);
                        sums[2][l] += longint'({1'b0, den_mem[i]})
                                      * longint'({1'b0, den_mem[j]});
                    end
                end
        res = '0;
        for (int q = 0; q < 3; q++) begin
            for (int l = 0; l < sacl_pkg::MaxRowLength; l++) c[l] = sums[q][l];
            lag[q] = half_lag(c, len, z);
            if (z) res.zero_energy[q] = 1'b1;
        end
        res.plane_number    = planes_done;
        res.momentum_lag    = lag[0][5:0];
        res.velocity_lag    = lag[1][5:0];
        res.density_lag     = lag[2][5:0];
        res.momentum_length = 22'(longint'(lag[0]) * spacing_reg);
        res.velocity_length = 22'(longint'(lag[1]) * spacing_reg);
        res.density_length  = 22'(longint'(lag[2]) * spacing_reg);
        expected_lengths = {expected_lengths, res};
        cells_held = 0;
        planes_done++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int p;
        if (no_idle) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // send one cell; called and returning at a falling edge, start left high
    task automatic send_cell(input sacl_pkg::t_in_item cur);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_item = cur;
        do @(posedge i_clk); while (busy);
        correlate_plane(cur);
        cells_sent++;
        @(negedge i_clk);
    endtask

    // wait until all results are in and the block is quiet
    task automatic wait_idle();
        start = 1'b0;
        @(negedge i_clk);
        while (expected_lengths.size() != 0 || busy) @(negedge i_clk);
        repeat (SettleCycles) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            sacl_pkg::REG_ROW_LENGTH:   row_len_reg = data[6:0];
            sacl_pkg::REG_ROW_COUNT:    row_cnt_reg = data[6:0];
            sacl_pkg::REG_CELL_SPACING: spacing_reg = data;
            default: ;
        endcase
    endtask

    task automatic configure(input int len, input int rows, input int spacing);
        wait_idle();
        cfg_write(sacl_pkg::REG_ROW_LENGTH, 16'(len));
        cfg_write(sacl_pkg::REG_ROW_COUNT, 16'(rows));
        cfg_write(sacl_pkg::REG_CELL_SPACING, 16'(spacing));
    endtask

    function automatic sacl_pkg::t_in_item make_cell(input int m, input int d, input bit last);
        sacl_pkg::t_in_item c;
        c.momentum_x = 16'(m);
        c.density = 16'(d);
        c.plane_end = last;
        return c;
    endfunction

    function automatic sacl_pkg::t_in_item random_cell(input bit last);
        int p;
        int d;
        p = $urandom_range(0, 9);
        d = (p == 0) ? $urandom_range(1, 16) : ((p == 1) ? 0 : $urandom_range(1, 65535));
        return make_cell($urandom, d, last);
    endfunction

    task automatic send_plane(input int count);
        for (int k = 0; k < count; k++) send_cell(random_cell(k == count - 1));
    endtask

    // field extremes, zero density, zero energy, short and long planes
    task automatic test_field_extremes();
        configure(4, 2, 256);
        send_cell(make_cell(-32768, 1, 0));
        send_cell(make_cell(32767, 1, 0));
        send_cell(make_cell(0, 65535, 0));
        send_cell(make_cell(-1, 0, 0));
        send_cell(make_cell(1, 65535, 0));
        send_cell(make_cell(-32768, 65535, 0));
        send_cell(make_cell(32767, 2, 0));
        send_cell(make_cell(100, 300, 1));
        // all zero: every lag-0 sum vanishes
        send_cell(make_cell(0, 0, 0));
        send_cell(make_cell(0, 0, 1));
        // short plane, then long plane
        send_cell(make_cell(500, 256, 0));
        send_cell(make_cell(-700, 128, 1));
        for (int k = 0; k < 11; k++) send_cell(random_cell(k == 10));
    endtask

    // constant row of three gives equal distances at lags 1 and 2
    task automatic test_ties();
        configure(3, 1, 1);
        for (int k = 0; k < 3; k++) send_cell(make_cell(256, 256, k == 2));
    endtask

    // register extremes, out-of-range values clamp
    task automatic test_register_extremes();
        configure(0, 0, 65535);
        send_plane(2);
        configure(127, 1, 65535);
        send_plane(64);
        configure(64, 1, 1);
        send_plane(64);
        configure(1, 127, 300);
        send_plane(64);
        configure(1, 64, 256);
        send_plane(64);
        configure(2, 2, 65535);
        send_plane(4);
    endtask

    task automatic test_random_planes();
        int len;
        int rows;
        int n;
        int p;
        len = 0;
        rows = 0;
        while (cells_sent < 750) begin
            if ($urandom_range(0, 4) == 0 || len == 0) begin
                len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, 64);
                rows = $urandom_range(1, (64 / len > 6) ? 6 : ((64 / len < 1) ? 1 : 64 / len));
                p = $urandom_range(0, 19);
                configure((p == 0) ? $urandom_range(65, 127) : len,
                          (p == 1) ? 0 : rows, $urandom_range(1, 65535));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            n = len * rows;
            p = $urandom_range(0, 9);
            if (p == 0) n = $urandom_range(1, n);
            else if (p == 1) n = n + $urandom_range(1, 4);
            send_plane(n);
        end
        no_idle = 1'b0;
    endtask

    // result checker
    always @(posedge i_clk) begin
        sacl_pkg::t_out_item want;
        if (i_rst_n && o_valid) begin
            if (expected_lengths.size() == 0) begin
                report_mismatch("unexpected result", o_item.plane_number, -1);
            end else begin
                want = expected_lengths.pop_front();
                if (o_item.plane_number != want.plane_number)
                    report_mismatch("plane_number", o_item.plane_number, want.plane_number);
                if (o_item.momentum_lag != want.momentum_lag)
                    report_mismatch("momentum_lag", o_item.momentum_lag, want.momentum_lag);
                if (o_item.velocity_lag != want.velocity_lag)
                    report_mismatch("velocity_lag", o_item.velocity_lag, want.velocity_lag);
                if (o_item.density_lag != want.density_lag)
                    report_mismatch("density_lag", o_item.density_lag, want.density_lag);
                if (o_item.momentum_length != want.momentum_length)
                    report_mismatch("momentum_length", o_item.momentum_length,
                                    want.momentum_length);
                if (o_item.velocity_length != want.velocity_length)
                    report_mismatch("velocity_length", o_item.velocity_length,
                                    want.velocity_length);
                if (o_item.density_length != want.density_length)
                    report_mismatch("density_length", o_item.density_length,
                                    want.density_length);
                if (o_item.zero_energy != want.zero_energy)
                    report_mismatch("zero_energy", o_item.zero_energy, want.zero_energy);
            end
        end
    end

    // watchdog on cycles with no item moving either way
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_field_extremes();
        test_ties();
        test_register_extremes();
        test_random_planes();
        wait_idle();
        if (expected_lengths.size() != 0)
            report_mismatch("results missing", 0, expected_lengths.size());
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
